// ===== hdl/rtps_pkg.sv =====
// relay table preferred select: shared types and constants
// used by rtps_front, rtps_back and the top level; no dependencies
`default_nettype none

package rtps_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;

   typedef enum logic [1:0] {
      KIND_TICK    = 2'd0,
      KIND_BEACON  = 2'd1,
      KIND_REROUTE = 2'd2,
      KIND_ISOLATE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_NONE     = 2'd0,
      STATUS_STORED   = 2'd1,
      STATUS_REJECTED = 2'd2,
      STATUS_FULL     = 2'd3
   } status_type;

   typedef enum logic {
      CSR_VISIBILITY_TIMEOUT = 1'b0,
      CSR_OWN_NODE_ID        = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE,
      ST_PICK,
      ST_EMIT
   } back_state_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] now_sec;
      logic [7:0]  sender_id;
      logic [7:0]  relay_channel;
      logic [15:0] isolate_duration;
      logic        rejected;
   } item_type;

   typedef struct packed {
      logic [7:0]  relay;
      logic [7:0]  channel;
      logic [31:0] seen_at;
   } entry_type;

endpackage

`default_nettype wire

// ===== hdl/rtps_ram.sv =====
// relay table preferred select: generic single write, single read ram
// registered read data; no dependencies
`default_nettype none

module rtps_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              write_enable,
   input  wire logic [ADDR_W-1:0] write_addr,
   input  wire logic [WIDTH-1:0]  write_data,
   input  wire logic [ADDR_W-1:0] read_addr,
   output logic      [WIDTH-1:0]  read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data <= mem_ff[read_addr];
   end

endmodule

`default_nettype wire

// ===== hdl/rtps_front.sv =====
// relay table preferred select: front end, accepts and classifies transactions
// and holds them in a short queue for the back end; uses rtps_pkg
`default_nettype none

module rtps_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [1:0]        req_kind,
   input  wire logic [31:0]       req_now_sec,
   input  wire logic [7:0]        req_relay_id,
   input  wire logic [7:0]        req_relay_channel,
   input  wire logic              req_is_forwarder,
   input  wire logic [15:0]       req_isolate_duration,
   input  wire logic [7:0]        own_node_id,
   output logic                   head_valid,
   output rtps_pkg::item_type     head,
   input  wire logic              pop
);
   import rtps_pkg::*;

   item_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   fill_ff, fill_in;
   logic                   push, do_pop;
   item_type               incoming;

   always_comb begin
      incoming.kind             = kind_type'(req_kind);
      incoming.now_sec          = req_now_sec;
      incoming.sender_id        = req_relay_id;
      incoming.relay_channel    = req_relay_channel;
      incoming.isolate_duration = req_isolate_duration;
      incoming.rejected         = (kind_type'(req_kind) == KIND_BEACON) &&
                                  (!req_is_forwarder || req_relay_id == 8'd0 ||
                                   req_relay_id == own_node_id);
   end

   assign busy       = (fill_ff == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];
   assign push       = start && !busy;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push && do_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/rtps_back.sv =====
// relay table preferred select: back end, table scans, beacon store and
// preferred relay choice; uses rtps_pkg and rtps_ram
`default_nettype none

module rtps_back #(
   parameter int TABLE_ENTRIES = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              head_valid,
   input  wire rtps_pkg::item_type head,
   output logic                   pop,
   input  wire logic [15:0]       visibility_timeout,
   output logic                   rsp_strobe,
   output logic [7:0]             rsp_preferred_relay,
   output logic [7:0]             rsp_isolated_relay,
   output logic [1:0]             rsp_status
);
   import rtps_pkg::*;

   localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
   localparam int ENTRY_W = $bits(entry_type);

   back_state_type    state_ff, state_in;
   item_type          cur_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  issue_ff;
   logic              rd_valid_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic              match_found_ff;
   logic [IDX_W-1:0]  match_slot_ff;
   logic              pref_found_ff;
   logic [31:0]       pref_seen_ff;
   logic [7:0]        preferred_ff;
   logic [7:0]        banned_id_ff;
   logic [31:0]       banned_until_ff;
   status_type        status_ff;
   logic              have_all_ff, have_skip_ff;
   logic [7:0]        all_id_ff, skip_id_ff;
   logic [31:0]       all_seen_ff, skip_seen_ff;

   logic              scanning, issuing, scan_done;
   logic              is_beacon, table_full, store, ban_active, pref_banned;
   logic              pref_visible, keep, rotate_req;
   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr;
   entry_type         ram_wentry, rd_entry;
   logic [ENTRY_W-1:0] ram_rdata;
   logic              rd_visible, rd_candidate;
   logic [31:0]       timeout_ext, age, ban_len;

   rtps_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock        (clock),
      .write_enable (ram_we),
      .write_addr   (ram_waddr),
      .write_data   (ram_wentry),
      .read_addr    (issue_ff[IDX_W-1:0]),
      .read_data    (ram_rdata)
   );

   assign rd_entry    = entry_type'(ram_rdata);
   assign timeout_ext = {16'd0, visibility_timeout};
   assign ban_len     = (head.isolate_duration == 16'd0) ? timeout_ext
                                                          : {16'd0, head.isolate_duration};

   // visibility and ban tests
   always_comb begin
      ban_active   = (banned_until_ff != 32'd0) && (cur_ff.now_sec < banned_until_ff);
      pref_banned  = (preferred_ff != 8'd0) && (banned_id_ff == preferred_ff) && ban_active;
      is_beacon    = (cur_ff.kind == KIND_BEACON);
      table_full   = is_beacon && !match_found_ff &&
                     (count_ff == CNT_W'(TABLE_ENTRIES));
      store        = is_beacon && !table_full;
      rotate_req   = (cur_ff.kind == KIND_REROUTE) || (cur_ff.kind == KIND_ISOLATE);
      if (store && cur_ff.sender_id == preferred_ff) begin
         pref_visible = 1'b1;
      end else begin
         pref_visible = pref_found_ff && (cur_ff.now_sec >= pref_seen_ff) &&
                        ((cur_ff.now_sec - pref_seen_ff) <= timeout_ext);
      end
      keep         = !rotate_req && pref_visible && !pref_banned;
      age          = cur_ff.now_sec - rd_entry.seen_at;
      rd_visible   = (cur_ff.now_sec >= rd_entry.seen_at) && (age <= timeout_ext);
      rd_candidate = rd_visible && !((rd_entry.relay != 8'd0) &&
                     (rd_entry.relay == banned_id_ff) && ban_active);
   end

   // control outputs
   always_comb begin
      pop        = (state_ff == ST_IDLE) && head_valid;
      scanning   = (state_ff == ST_LOOKUP) || (state_ff == ST_PICK);
      issuing    = scanning && (issue_ff < count_ff);
      scan_done  = scanning && !issuing && !rd_valid_ff;
      ram_we     = (state_ff == ST_UPDATE) && store;
      ram_waddr  = match_found_ff ? match_slot_ff : count_ff[IDX_W-1:0];
      ram_wentry.relay   = cur_ff.sender_id;
      ram_wentry.channel = cur_ff.relay_channel;
      ram_wentry.seen_at = cur_ff.now_sec;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               state_in = head.rejected ? ST_EMIT : ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (scan_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = (table_full || keep) ? ST_EMIT : ST_PICK;
         end
         ST_PICK: begin
            if (scan_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         count_ff        <= '0;
         issue_ff        <= '0;
         rd_valid_ff     <= 1'b0;
         preferred_ff    <= 8'd0;
         banned_id_ff    <= 8'd0;
         banned_until_ff <= 32'd0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= issuing;
         if (!scanning) begin
            issue_ff <= '0;
         end else if (issuing) begin
            issue_ff <= issue_ff + 1'b1;
         end
         if (pop && !head.rejected && head.kind == KIND_ISOLATE &&
             preferred_ff != 8'd0) begin
            banned_id_ff    <= preferred_ff;
            banned_until_ff <= head.now_sec + ban_len;
         end
         if (state_ff == ST_UPDATE && !table_full) begin
            if (store && !match_found_ff) begin
               count_ff <= count_ff + 1'b1;
            end
            // ban expiry checked on every update that does not find the table full
            if (banned_until_ff != 32'd0 && cur_ff.now_sec >= banned_until_ff) begin
               banned_id_ff    <= 8'd0;
               banned_until_ff <= 32'd0;
            end
         end
         if (state_ff == ST_PICK && scan_done) begin
            preferred_ff <= have_skip_ff ? skip_id_ff : (have_all_ff ? all_id_ff : 8'd0);
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= issue_ff[IDX_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               cur_ff         <= head;
               status_ff      <= head.rejected ? STATUS_REJECTED : STATUS_NONE;
               match_found_ff <= 1'b0;
               pref_found_ff  <= 1'b0;
            end
         end
         ST_LOOKUP: begin
            if (rd_valid_ff) begin
               if (is_beacon && !match_found_ff && rd_entry.relay == cur_ff.sender_id) begin
                  match_found_ff <= 1'b1;
                  match_slot_ff  <= rd_idx_ff;
               end
               if (preferred_ff != 8'd0 && rd_entry.relay == preferred_ff) begin
                  pref_found_ff <= 1'b1;
                  pref_seen_ff  <= rd_entry.seen_at;
               end
            end
         end
         ST_UPDATE: begin
            if (table_full) begin
               status_ff <= STATUS_FULL;
            end else if (store) begin
               status_ff <= STATUS_STORED;
            end
            have_all_ff  <= 1'b0;
            have_skip_ff <= 1'b0;
         end
         ST_PICK: begin
            if (rd_valid_ff && rd_candidate) begin
               if (!have_all_ff || rd_entry.seen_at >= all_seen_ff) begin
                  have_all_ff <= 1'b1;
                  all_id_ff   <= rd_entry.relay;
                  all_seen_ff <= rd_entry.seen_at;
               end
               if (rd_entry.relay != preferred_ff &&
                   (!have_skip_ff || rd_entry.seen_at >= skip_seen_ff)) begin
                  have_skip_ff <= 1'b1;
                  skip_id_ff   <= rd_entry.relay;
                  skip_seen_ff <= rd_entry.seen_at;
               end
            end
         end
         ST_EMIT: begin
         end
         default: begin
         end
      endcase
   end

   assign rsp_strobe          = (state_ff == ST_EMIT);
   assign rsp_preferred_relay = preferred_ff;
   assign rsp_isolated_relay  = (banned_id_ff != 8'd0 && ban_active) ? banned_id_ff : 8'd0;
   assign rsp_status          = status_ff;

endmodule

`default_nettype wire

// ===== hdl/relay_table_preferred_select_unit.sv =====
// relay table preferred select: top level with configuration registers
// instantiates rtps_front and rtps_back; uses rtps_pkg
//
// usage: a transaction is taken at a clock edge with start high and busy low.
// the front end filters beacons and queues up to two transactions, so busy
// rises only when that queue is full while the back end is working.
// the back end scans the relay table in ram, one entry per cycle: a lookup
// pass, an update cycle, and when the choice must change a second pick pass.
// one transaction is carried out at a time, so a queued one starts only
// after the result of the previous one has been emitted.
// each result is shown for exactly one cycle with rsp_strobe high; there is
// no back-pressure on the result side.
// configuration: csr_write_enable with csr_index 0 for the visibility timeout
// and 1 for the own node id, taken at once; the user must write them only
// while the block is idle, which the block itself does not enforce.
// reset empties the table and the queue, clears the preferred and isolated
// relays and loads a timeout of 10 and an own node id of 0.
`default_nettype none

module relay_table_preferred_select_unit #(
   parameter int TABLE_ENTRIES = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_kind,
   input  wire logic [31:0] req_now_sec,
   input  wire logic [7:0]  req_relay_id,
   input  wire logic [7:0]  req_relay_channel,
   input  wire logic        req_is_forwarder,
   input  wire logic [15:0] req_isolate_duration,
   output logic             rsp_strobe,
   output logic [7:0]       rsp_preferred_relay,
   output logic [7:0]       rsp_isolated_relay,
   output logic [1:0]       rsp_status,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_write_data
);
   import rtps_pkg::*;

   logic [15:0] timeout_ff;
   logic [7:0]  own_id_ff;
   logic        head_valid, pop;
   item_type    head;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= 16'd10;
         own_id_ff  <= 8'd0;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_VISIBILITY_TIMEOUT: begin
               timeout_ff <= csr_write_data;
            end
            CSR_OWN_NODE_ID: begin
               own_id_ff <= csr_write_data[7:0];
            end
            default: begin
            end
         endcase
      end
   end

   rtps_front u_front (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_kind             (req_kind),
      .req_now_sec          (req_now_sec),
      .req_relay_id         (req_relay_id),
      .req_relay_channel    (req_relay_channel),
      .req_is_forwarder     (req_is_forwarder),
      .req_isolate_duration (req_isolate_duration),
      .own_node_id          (own_id_ff),
      .head_valid           (head_valid),
      .head                 (head),
      .pop                  (pop)
   );

   rtps_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .head_valid          (head_valid),
      .head                (head),
      .pop                 (pop),
      .visibility_timeout  (timeout_ff),
      .rsp_strobe          (rsp_strobe),
      .rsp_preferred_relay (rsp_preferred_relay),
      .rsp_isolated_relay  (rsp_isolated_relay),
      .rsp_status          (rsp_status)
   );

endmodule

`default_nettype wire
